// ===== design/scem_pkg.sv =====
// Shared types, constants and codes for the Scharr edge magnitude core.
`default_nettype none
package scem_pkg;

  // Line store geometry
  localparam int unsigned MaxWidth = 1024;
  localparam int unsigned AddrW    = $clog2(MaxWidth);
  localparam int unsigned ColW     = AddrW;

  // Field widths
  localparam int unsigned PixW     = 8;
  localparam int unsigned WidthW   = 11;
  localparam int unsigned HeightW  = 12;
  localparam int unsigned RowW     = HeightW;
  localparam int unsigned PendW    = WidthW;
  localparam int unsigned CfgIdxW  = 1;
  localparam int unsigned CfgDataW = 12;
  localparam int unsigned GradW    = 14;

  // Register reset values
  localparam logic [WidthW-1:0]  FrameWidthRst  = WidthW'(640);
  localparam logic [HeightW-1:0] FrameHeightRst = HeightW'(480);

  // Scharr weights
  localparam int SideCoef   = 3;
  localparam int CenterCoef = 10;

  // Input word kinds
  localparam logic KindPixel = 1'b0;
  localparam logic KindDrain = 1'b1;

  // Window positions, oldest column or row first
  localparam logic [1:0] TapOld = 2'd0;
  localparam logic [1:0] TapMid = 2'd1;
  localparam logic [1:0] TapNew = 2'd2;

  // Configuration register indexes
  typedef enum logic [CfgIdxW-1:0] {
    CfgFrameWidth  = 1'b0,
    CfgFrameHeight = 1'b1
  } scem_cfg_e;

  typedef struct packed {
    logic            kind;
    logic [PixW-1:0] pixel;
  } scem_in_t;

  typedef struct packed {
    logic [PixW-1:0] grad_x_mag;
    logic [PixW-1:0] grad_y_mag;
    logic [PixW-1:0] edge_mag;
    logic            end_of_frame;
  } scem_out_t;

  // 3x3 neighborhood, [row][col]
  typedef logic [2:0][2:0][PixW-1:0] scem_win_t;

  // How the result is picked out of the window
  typedef struct packed {
    logic       pre;   // window before this word's shift
    logic       top2;  // top row reflects to the bottom row
    logic [1:0] lc;
    logic [1:0] mc;
    logic [1:0] rc;
    logic       eof;
  } scem_sel_t;

  // Decoded word handed from the sequencer to the working stage
  typedef struct packed {
    logic             act;       // shifts the window
    logic             is_pixel;
    logic [AddrW-1:0] addr;
    logic             emit;
    scem_sel_t        sel;
  } scem_item_t;

endpackage
`default_nettype wire

// ===== design/scharr_edge_magnitude_core.sv =====
// Top level of the streaming Scharr 3x3 edge magnitude core.
`default_nettype none
// Takes one word per clock on the input channel while the output accepts
// results: a grey pixel in raster order or a drain word. The row stores are
// two simple dual-port RAMs of one row each; a word's column is read as the
// word is taken into the working stage register, and when that stage moves on
// it shifts the 3x3 window, writes the column back and forms the gradients
// into the output register. Results lag the pixels by one row plus one
// pixel; after the last pixel of a frame, width+1 drain words release the
// remaining results, the last one flagged with end_of_frame. A pixel taken
// while drain results are still owed starts a new frame and drops them. The
// row stores are not cleared after reset: border reflection keeps unwritten
// entries away from every result. Configuration writes are taken at once and
// restart the frame; write them only while the core is idle.
module scharr_edge_magnitude_core (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  scem_pkg::scem_in_t            in_data_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output scem_pkg::scem_out_t           out_data_o,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [scem_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  logic [scem_pkg::CfgDataW-1:0] cfg_data_i
);

  scem_pkg::scem_item_t      in_item;
  scem_pkg::scem_item_t      s1_item_q;
  logic                      s1_valid_q, s1_valid_d;
  logic [scem_pkg::PixW-1:0] s1_pix_q;
  logic                      in_accept;
  logic                      s1_go;
  logic                      out_free;
  logic                      ram_we;
  logic [scem_pkg::PixW-1:0] older_rd, newer_rd;
  scem_pkg::scem_win_t       win_q, post_win, src_win, taps;
  logic [2:0][1:0]           row_sel, col_sel;
  scem_pkg::scem_out_t       result;
  scem_pkg::scem_out_t       out_data_q;
  logic                      out_valid_q, out_valid_d;

  assign cfg_ready_o = 1'b1;

  // handshake: the working stage moves when its result has a place to go
  assign out_free   = !out_valid_q || out_ready_i;
  assign s1_go      = s1_valid_q && (!s1_item_q.emit || out_free);
  assign in_ready_o = !s1_valid_q || s1_go;
  assign in_accept  = in_valid_i && in_ready_o;
  assign ram_we     = s1_go && s1_item_q.act && s1_item_q.is_pixel;

  scem_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .accept_i    (in_accept),
    .kind_i      (in_data_i.kind),
    .item_o      (in_item)
  );

  // row store holding the row before the newest one
  scem_ram #(
    .Width (scem_pkg::PixW),
    .Depth (scem_pkg::MaxWidth)
  ) u_older (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (s1_item_q.addr),
    .wdata_i (newer_rd),
    .re_i    (in_accept),
    .raddr_i (in_item.addr),
    .rdata_o (older_rd)
  );

  // row store holding the newest complete row
  scem_ram #(
    .Width (scem_pkg::PixW),
    .Depth (scem_pkg::MaxWidth)
  ) u_newer (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (s1_item_q.addr),
    .wdata_i (s1_pix_q),
    .re_i    (in_accept),
    .raddr_i (in_item.addr),
    .rdata_o (newer_rd)
  );

  // working stage register
  assign s1_valid_d = in_accept ? 1'b1 : (s1_go ? 1'b0 : s1_valid_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= s1_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      s1_item_q <= in_item;
      s1_pix_q  <= in_data_i.pixel;
    end
  end

  // window shift; drains feed the older row into the bottom row as well
  always_comb begin
    for (int r = 0; r < 3; r++) begin
      post_win[r][0] = win_q[r][1];
      post_win[r][1] = win_q[r][2];
    end
    post_win[0][2] = older_rd;
    post_win[1][2] = newer_rd;
    post_win[2][2] = s1_item_q.is_pixel ? s1_pix_q : older_rd;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      win_q <= '0;
    end else if (s1_go && s1_item_q.act) begin
      win_q <= post_win;
    end
  end

  // pick the neighborhood with border reflection
  always_comb begin
    src_win    = s1_item_q.sel.pre ? win_q : post_win;
    row_sel[0] = s1_item_q.sel.top2 ? scem_pkg::TapNew : scem_pkg::TapOld;
    row_sel[1] = scem_pkg::TapMid;
    row_sel[2] = scem_pkg::TapNew;
    col_sel[0] = s1_item_q.sel.lc;
    col_sel[1] = s1_item_q.sel.mc;
    col_sel[2] = s1_item_q.sel.rc;
    for (int r = 0; r < 3; r++) begin
      for (int k = 0; k < 3; k++) begin
        taps[r][k] = src_win[row_sel[r]][col_sel[k]];
      end
    end
  end

  scem_grad u_grad (
    .taps_i   (taps),
    .eof_i    (s1_item_q.sel.eof),
    .result_o (result)
  );

  // output register
  always_comb begin
    if (s1_go && s1_item_q.emit) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_go && s1_item_q.emit) begin
      out_data_q <= result;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

  // a column write never meets a live read of the same column
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ram_we && in_accept && in_item.act) |-> (s1_item_q.addr != in_item.addr))
    else $error("row store read and write collide on one column");

  // a held word keeps its row store data
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_valid_q && !s1_go) |=> ($stable(older_rd) && $stable(newer_rd)))
    else $error("row store data lost while the word is held");

endmodule
`default_nettype wire

// ===== design/scem_ram.sv =====
// Generic simple dual-port RAM with registered read.
`default_nettype none
module scem_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // read port, data held until the next read
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule
`default_nettype wire

// ===== design/scem_ctrl.sv =====
// Frame registers, raster counters and drain sequencing for the edge core.
`default_nettype none
module scem_ctrl (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_valid_i,
  input  logic [scem_pkg::CfgIdxW-1:0]   cfg_index_i,
  input  logic [scem_pkg::CfgDataW-1:0]  cfg_data_i,
  input  logic                           accept_i,
  input  logic                           kind_i,
  output scem_pkg::scem_item_t           item_o
);

  logic [scem_pkg::WidthW-1:0]  frame_width_q, frame_width_d;
  logic [scem_pkg::HeightW-1:0] frame_height_q, frame_height_d;
  logic [scem_pkg::ColW-1:0]    col_q, col_d;
  logic [scem_pkg::RowW-1:0]    row_q, row_d;
  logic [scem_pkg::PendW-1:0]   pend_q, pend_d;

  logic [scem_pkg::WidthW-1:0]  w_eff;
  logic [scem_pkg::HeightW-1:0] h_eff;
  logic [scem_pkg::ColW-1:0]    col_cur;
  logic [scem_pkg::ColW:0]      col_inc;
  logic [scem_pkg::RowW-1:0]    row_cur;
  logic [scem_pkg::RowW:0]      row_inc;
  logic                         col_wrap;
  logic                         row_wrap;
  logic [scem_pkg::PendW-1:0]   w_plus1;
  logic [scem_pkg::PendW-1:0]   drain_k;
  logic                         is_pixel;

  // effective frame size
  always_comb begin
    if (frame_width_q < scem_pkg::WidthW'(2)) begin
      w_eff = scem_pkg::WidthW'(2);
    end else if (32'(frame_width_q) > scem_pkg::MaxWidth) begin
      w_eff = scem_pkg::WidthW'(scem_pkg::MaxWidth);
    end else begin
      w_eff = frame_width_q;
    end
    if (frame_height_q < scem_pkg::HeightW'(2)) begin
      h_eff = scem_pkg::HeightW'(2);
    end else begin
      h_eff = frame_height_q;
    end
  end

  // raster position of the current word
  always_comb begin
    col_cur  = (col_q >= w_eff) ? '0 : col_q;
    row_cur  = (row_q >= h_eff) ? '0 : row_q;
    col_inc  = (scem_pkg::ColW+1)'(col_cur) + (scem_pkg::ColW+1)'(1);
    row_inc  = (scem_pkg::RowW+1)'(row_cur) + (scem_pkg::RowW+1)'(1);
    col_wrap = (col_inc >= w_eff);
    row_wrap = (row_inc >= h_eff);
    w_plus1  = scem_pkg::PendW'(w_eff) + scem_pkg::PendW'(1);
    drain_k  = w_plus1 - pend_q;
    is_pixel = (kind_i == scem_pkg::KindPixel);
  end

  // decode the word being taken
  always_comb begin
    item_o          = '0;
    item_o.is_pixel = is_pixel;
    if (is_pixel) begin
      item_o.act  = 1'b1;
      item_o.addr = col_cur[scem_pkg::AddrW-1:0];
      if (col_cur == '0 && row_cur >= scem_pkg::RowW'(2)) begin
        // right edge pixel of the row two back, before the shift
        item_o.emit     = 1'b1;
        item_o.sel.pre  = 1'b1;
        item_o.sel.top2 = (row_cur == scem_pkg::RowW'(2));
        item_o.sel.lc   = scem_pkg::TapMid;
        item_o.sel.mc   = scem_pkg::TapNew;
        item_o.sel.rc   = scem_pkg::TapMid;
      end else if (col_cur != '0 && row_cur != '0) begin
        // previous column of the row above, after the shift
        item_o.emit     = 1'b1;
        item_o.sel.top2 = (row_cur == scem_pkg::RowW'(1));
        item_o.sel.lc   = (col_cur == scem_pkg::ColW'(1)) ? scem_pkg::TapNew
                                                           : scem_pkg::TapOld;
        item_o.sel.mc   = scem_pkg::TapMid;
        item_o.sel.rc   = scem_pkg::TapNew;
      end
    end else begin
      item_o.act     = (pend_q != '0);
      item_o.emit    = (pend_q != '0);
      item_o.addr    = drain_k[scem_pkg::AddrW-1:0];
      item_o.sel.eof = (pend_q == scem_pkg::PendW'(1));
      if (pend_q == w_plus1) begin
        // last pixel of the next-to-last row
        item_o.sel.pre  = 1'b1;
        item_o.sel.top2 = (h_eff == scem_pkg::HeightW'(2));
        item_o.sel.lc   = scem_pkg::TapMid;
        item_o.sel.mc   = scem_pkg::TapNew;
        item_o.sel.rc   = scem_pkg::TapMid;
      end else begin
        // last row; its bottom neighbor reflects to the row above
        item_o.sel.lc = (pend_q == scem_pkg::PendW'(w_eff)) ? scem_pkg::TapNew
                                                            : scem_pkg::TapOld;
        item_o.sel.mc = scem_pkg::TapMid;
        item_o.sel.rc = (pend_q == scem_pkg::PendW'(1)) ? scem_pkg::TapOld
                                                        : scem_pkg::TapNew;
      end
    end
  end

  // next state of registers and counters
  always_comb begin
    frame_width_d  = frame_width_q;
    frame_height_d = frame_height_q;
    col_d          = col_q;
    row_d          = row_q;
    pend_d         = pend_q;
    if (cfg_valid_i) begin
      case (cfg_index_i)
        scem_pkg::CfgFrameWidth: begin
          frame_width_d = cfg_data_i[scem_pkg::WidthW-1:0];
        end
        scem_pkg::CfgFrameHeight: begin
          frame_height_d = cfg_data_i[scem_pkg::HeightW-1:0];
        end
        default: begin
        end
      endcase
      col_d  = '0;
      row_d  = '0;
      pend_d = '0;
    end else if (accept_i) begin
      if (is_pixel) begin
        pend_d = '0;
        if (col_wrap) begin
          col_d = '0;
          if (row_wrap) begin
            row_d  = '0;
            pend_d = w_plus1;
          end else begin
            row_d = row_inc[scem_pkg::RowW-1:0];
          end
        end else begin
          col_d = col_inc[scem_pkg::ColW-1:0];
          row_d = row_cur;
        end
      end else if (pend_q != '0) begin
        pend_d = pend_q - scem_pkg::PendW'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frame_width_q  <= scem_pkg::FrameWidthRst;
      frame_height_q <= scem_pkg::FrameHeightRst;
      col_q          <= '0;
      row_q          <= '0;
      pend_q         <= '0;
    end else begin
      frame_width_q  <= frame_width_d;
      frame_height_q <= frame_height_d;
      col_q          <= col_d;
      row_q          <= row_d;
      pend_q         <= pend_d;
    end
  end

  // counters stay inside the frame they belong to
  assert property (@(posedge clk_i) disable iff (!rst_ni) pend_q <= w_plus1)
    else $error("drain count beyond one row plus one pixel");
  assert property (@(posedge clk_i) disable iff (!rst_ni) col_q < w_eff)
    else $error("column count outside the row");
  assert property (@(posedge clk_i) disable iff (!rst_ni) row_q < h_eff)
    else $error("row count outside the frame");

endmodule
`default_nettype wire

// ===== design/scem_grad.sv =====
// Scharr gradients, saturated magnitudes and their maximum for one window.
`default_nettype none
module scem_grad (
  input  scem_pkg::scem_win_t taps_i,
  input  logic                eof_i,
  output scem_pkg::scem_out_t result_o
);

  logic signed [scem_pkg::PixW:0]    dx_top, dx_mid, dx_bot;
  logic signed [scem_pkg::PixW:0]    dy_lft, dy_mid, dy_rgt;
  logic signed [scem_pkg::GradW-1:0] gx, gy;
  logic [scem_pkg::PixW-1:0]         mag_x, mag_y;

  function automatic logic [scem_pkg::PixW-1:0] sat_abs(
    input logic signed [scem_pkg::GradW-1:0] v
  );
    logic [scem_pkg::GradW-1:0] m;
    m = v[scem_pkg::GradW-1] ? scem_pkg::GradW'(-v) : scem_pkg::GradW'(v);
    if (m > scem_pkg::GradW'(2**scem_pkg::PixW - 1)) begin
      return '1;
    end
    return m[scem_pkg::PixW-1:0];
  endfunction

  // column and row differences
  always_comb begin
    dx_top = $signed({1'b0, taps_i[0][2]}) - $signed({1'b0, taps_i[0][0]});
    dx_mid = $signed({1'b0, taps_i[1][2]}) - $signed({1'b0, taps_i[1][0]});
    dx_bot = $signed({1'b0, taps_i[2][2]}) - $signed({1'b0, taps_i[2][0]});
    dy_lft = $signed({1'b0, taps_i[2][0]}) - $signed({1'b0, taps_i[0][0]});
    dy_mid = $signed({1'b0, taps_i[2][1]}) - $signed({1'b0, taps_i[0][1]});
    dy_rgt = $signed({1'b0, taps_i[2][2]}) - $signed({1'b0, taps_i[0][2]});
  end

  // 3,10,3 weighting
  always_comb begin
    gx = scem_pkg::GradW'(dx_top) * scem_pkg::GradW'(scem_pkg::SideCoef)
       + scem_pkg::GradW'(dx_mid) * scem_pkg::GradW'(scem_pkg::CenterCoef)
       + scem_pkg::GradW'(dx_bot) * scem_pkg::GradW'(scem_pkg::SideCoef);
    gy = scem_pkg::GradW'(dy_lft) * scem_pkg::GradW'(scem_pkg::SideCoef)
       + scem_pkg::GradW'(dy_mid) * scem_pkg::GradW'(scem_pkg::CenterCoef)
       + scem_pkg::GradW'(dy_rgt) * scem_pkg::GradW'(scem_pkg::SideCoef);
  end

  // magnitudes and edge strength
  always_comb begin
    mag_x                 = sat_abs(gx);
    mag_y                 = sat_abs(gy);
    result_o.grad_x_mag   = mag_x;
    result_o.grad_y_mag   = mag_y;
    result_o.edge_mag     = (mag_x > mag_y) ? mag_x : mag_y;
    result_o.end_of_frame = eof_i;
  end

endmodule
`default_nettype wire

// ===== tb/tb_scharr_edge_magnitude_core.sv =====
// Testbench for the streaming Scharr 3x3 edge magnitude core.
`timescale 1ns / 100ps
module tb_scharr_edge_magnitude_core;
  import scem_pkg::*;

  localparam int unsigned CycleLimit   = 600000;
  localparam int unsigned SettleCycles = 8;
  localparam int unsigned IdlePct      = 37;
  localparam int unsigned RandomWords  = 100;

  // DUT connections
  logic                clk_i       = 1'b0;
  logic                rst_ni      = 1'b0;
  logic                in_valid_i  = 1'b0;
  logic                in_ready_o;
  scem_in_t            in_data_i   = '0;
  logic                out_valid_o;
  logic                out_ready_i = 1'b0;
  scem_out_t           out_data_o;
  logic                cfg_valid_i = 1'b0;
  logic                cfg_ready_o;
  logic [CfgIdxW-1:0]  cfg_index_i = '0;
  logic [CfgDataW-1:0] cfg_data_i  = '0;

  // Run bookkeeping
  bit          steady = 1'b0;  // no idling on either side while set
  int unsigned cycle_count = 0;
  int unsigned mismatches = 0;
  int unsigned words_sent = 0;
  int unsigned drains_sent = 0;
  int unsigned results_checked = 0;
  int unsigned reg_writes = 0;
  scem_out_t   edge_results_q[$];

  // Predictor state
  logic [PixW-1:0] older_line [MaxWidth];
  logic [PixW-1:0] newer_line [MaxWidth];
  logic [PixW-1:0] win [9];  // row*3+col, row 0 oldest, col 2 newest
  int unsigned     width_reg, height_reg, col_pos, row_pos, owed_drains;
  int              nb [3][3];

  scharr_edge_magnitude_core DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i)
  );

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  // Watchdog
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CycleLimit) begin
      $display("%0t timeout after %0d cycles, %0d results outstanding", $time,
               cycle_count, edge_results_q.size());
      $display("TB_ERROR");
      $finish;
    end
  end

  // Output side backpressure
  always @(posedge clk_i) begin
    out_ready_i <= steady || ($urandom_range(0, 99) >= IdlePct);
  end

  // ---------------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------------
  function automatic int unsigned eff_width();
    if (width_reg < 2) return 2;
    if (width_reg > MaxWidth) return MaxWidth;
    return width_reg;
  endfunction

  function automatic int unsigned eff_height();
    return (height_reg < 2) ? 2 : height_reg;
  endfunction

  function automatic logic [PixW-1:0] sat_mag(input int v);
    if (v < 0) v = -v;
    return (v > 255) ? 8'd255 : v[PixW-1:0];
  endfunction

  function automatic scem_out_t form_result(input bit eof);
    int        gx, gy;
    scem_out_t r;
    gx = SideCoef * (nb[0][2] - nb[0][0]) + CenterCoef * (nb[1][2] - nb[1][0])
       + SideCoef * (nb[2][2] - nb[2][0]);
    gy = SideCoef * (nb[2][0] - nb[0][0]) + CenterCoef * (nb[2][1] - nb[0][1])
       + SideCoef * (nb[2][2] - nb[0][2]);
    r.grad_x_mag   = sat_mag(gx);
    r.grad_y_mag   = sat_mag(gy);
    r.edge_mag     = (r.grad_x_mag > r.grad_y_mag) ? r.grad_x_mag : r.grad_y_mag;
    r.end_of_frame = eof;
    return r;
  endfunction

  // Neighborhood out of the window: top row from top_row, rows 1 and 2 as they are
  task automatic pick_window(input int top_row, input int lc, input int mc, input int rc);
    int rows [3];
    int cols [3];
    rows = '{top_row, 1, 2};
    cols = '{lc, mc, rc};
    for (int r = 0; r < 3; r++) begin
      for (int k = 0; k < 3; k++) nb[r][k] = win[rows[r] * 3 + cols[k]];
    end
  endtask

  task automatic model_reset();
    width_reg   = FrameWidthRst;
    height_reg  = FrameHeightRst;
    col_pos     = 0;
    row_pos     = 0;
    owed_drains = 0;
    foreach (older_line[j]) older_line[j] = '0;
    foreach (newer_line[j]) newer_line[j] = '0;
    foreach (win[j]) win[j] = '0;
  endtask

  // Expected result, if any, of one accepted input word
  task automatic scharr_predict(input scem_in_t w);
    int unsigned ww, hh, k, c, i, ix;
    int unsigned cx [3];
    ww = eff_width();
    hh = eff_height();
    if (w.kind == KindDrain) begin
      if (owed_drains == 0 || owed_drains > ww + 1) return;
      k = ww + 1 - owed_drains;
      if (k == 0) begin
        // last pixel of the next-to-last row, still in the window
        pick_window((hh == 2) ? TapNew : TapOld, TapMid, TapNew, TapMid);
      end else begin
        // last row, bottom neighbor reflects to the row above
        c = k - 1;
        cx[0] = (c == 0) ? 1 : c - 1;
        cx[1] = c;
        cx[2] = (c + 1 >= ww) ? ww - 2 : c + 1;
        for (int j = 0; j < 3; j++) begin
          nb[0][j] = older_line[cx[j] % MaxWidth];
          nb[1][j] = newer_line[cx[j] % MaxWidth];
          nb[2][j] = older_line[cx[j] % MaxWidth];
        end
      end
      owed_drains--;
      edge_results_q.push_back(form_result(owed_drains == 0));
      return;
    end

    // Pixel: drops owed drain results and advances the raster position
    owed_drains = 0;
    c = (col_pos >= ww) ? 0 : col_pos;
    i = (row_pos >= hh) ? 0 : row_pos;
    ix = c % MaxWidth;
    if (c == 0 && i >= 2) begin
      // right edge of the row two back, before the shift
      pick_window((i == 2) ? TapNew : TapOld, TapMid, TapNew, TapMid);
      edge_results_q.push_back(form_result(1'b0));
    end
    for (int r = 0; r < 3; r++) begin
      win[r * 3 + 0] = win[r * 3 + 1];
      win[r * 3 + 1] = win[r * 3 + 2];
    end
    win[2] = older_line[ix];
    win[5] = newer_line[ix];
    win[8] = w.pixel;
    older_line[ix] = newer_line[ix];
    newer_line[ix] = w.pixel;
    if (c >= 1 && i >= 1) begin
      pick_window((i == 1) ? TapNew : TapOld, (c == 1) ? TapNew : TapOld, TapMid, TapNew);
      edge_results_q.push_back(form_result(1'b0));
    end
    c++;
    if (c >= ww) begin
      c = 0;
      i++;
      if (i >= hh) begin
        i = 0;
        owed_drains = ww + 1;
      end
    end
    col_pos = c;
    row_pos = i;
  endtask

  // ---------------------------------------------------------------------------
  // Result checking
  // ---------------------------------------------------------------------------
  task automatic check_field(input string name, input int want, input int got);
    if (want != got) begin
      $display("%0t mismatch on %s: expected %0d, actual %0d", $time, name, want, got);
      mismatches++;
    end
  endtask

  always @(posedge clk_i) begin
    scem_out_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (edge_results_q.size() == 0) begin
        $display("%0t unexpected result word: expected none, actual %h", $time,
                 out_data_o);
        mismatches++;
      end else begin
        want = edge_results_q.pop_front();
        check_field("grad_x_mag", want.grad_x_mag, out_data_o.grad_x_mag);
        check_field("grad_y_mag", want.grad_y_mag, out_data_o.grad_y_mag);
        check_field("edge_mag", want.edge_mag, out_data_o.edge_mag);
        check_field("end_of_frame", want.end_of_frame, out_data_o.end_of_frame);
        results_checked++;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Drivers
  // ---------------------------------------------------------------------------
  task automatic send_word(input logic kind, input logic [PixW-1:0] pix);
    scem_in_t w;
    w.kind  = kind;
    w.pixel = pix;
    while (!steady && $urandom_range(0, 99) < IdlePct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= w;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    scharr_predict(w);
    words_sent++;
    if (kind == KindDrain) drains_sent++;
  endtask

  // Sender stops until every expected result is out and the pipe has emptied
  task automatic wait_idle();
    in_valid_i <= 1'b0;
    while (edge_results_q.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic write_reg(input scem_cfg_e idx, input logic [CfgDataW-1:0] val);
    wait_idle();
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    cfg_valid_i <= 1'b0;
    if (idx == CfgFrameWidth) width_reg = val & 12'h7FF;
    else height_reg = val;
    col_pos     = 0;
    row_pos     = 0;
    owed_drains = 0;
    reg_writes++;
  endtask

  task automatic set_frame(input logic [CfgDataW-1:0] w, input logic [CfgDataW-1:0] h);
    write_reg(CfgFrameWidth, w);
    write_reg(CfgFrameHeight, h);
  endtask

  // Mostly full range, often the extremes so gradients saturate
  function automatic logic [PixW-1:0] rand_pixel();
    if ($urandom_range(0, 3) == 0) return $urandom_range(0, 1) ? 8'hFF : 8'h00;
    return PixW'($urandom_range(0, 255));
  endfunction

  task automatic send_frame(input int unsigned pixels, input int unsigned drains);
    repeat (pixels) send_word(KindPixel, rand_pixel());
    repeat (drains) send_word(KindDrain, rand_pixel());
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Drain with nothing owed, then a few pixels under the reset geometry
  task automatic test_startup();
    send_word(KindDrain, 8'hFF);
    send_word(KindPixel, 8'h00);
    send_word(KindPixel, 8'hFF);
    send_word(KindPixel, 8'h80);
  endtask

  // Width and height written below range act as 2x2
  task automatic test_tiny_frame();
    set_frame(12'd0, 12'd1);
    send_word(KindPixel, 8'h00);
    send_word(KindPixel, 8'hFF);
    send_word(KindPixel, 8'hFF);
    send_word(KindPixel, 8'h00);
    repeat (3) send_word(KindDrain, 8'h00);
    send_word(KindDrain, 8'hFF);  // nothing owed any more
  endtask

  // 3x3 borders, then a new frame started while drains are owed
  task automatic test_border_and_restart();
    logic [PixW-1:0] checker_pat [9];
    logic [PixW-1:0] bit_pat [9];
    checker_pat = '{8'hFF, 8'h00, 8'hFF, 8'h00, 8'hFF, 8'h00, 8'hFF, 8'h00, 8'hFF};
    bit_pat     = '{8'h01, 8'h02, 8'h04, 8'h08, 8'h10, 8'h20, 8'h40, 8'h80, 8'hFF};
    set_frame(12'd3, 12'd3);
    foreach (checker_pat[j]) send_word(KindPixel, checker_pat[j]);
    send_word(KindDrain, 8'h00);
    foreach (bit_pat[j]) send_word(KindPixel, bit_pat[j]);
    repeat (4) send_word(KindDrain, 8'h00);
  endtask

  // Width written past the store size acts as the widest row; one row and a bit
  task automatic test_size_extremes();
    set_frame(12'hFFF, 12'd0);
    send_frame(MaxWidth + 6, 0);
  endtask

  // Full rate on both sides, frames back to back
  task automatic test_back_to_back();
    steady = 1'b1;
    set_frame(12'd5, 12'd4);
    repeat (3) send_frame(20, 6);
    send_frame(20, 0);
    send_frame(20, 6);
    wait_idle();
    steady = 1'b0;
  endtask

  // Random geometry; mostly whole frames, some broken ones and noise
  task automatic test_random_frames();
    int unsigned first_word, w_set, h_set, ww, hh, frames, mode;
    first_word = words_sent;
    while (words_sent - first_word < RandomWords) begin
      w_set = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 1) : $urandom_range(2, 12);
      h_set = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 1) : $urandom_range(2, 6);
      set_frame(CfgDataW'(w_set), CfgDataW'(h_set));
      ww = (w_set < 2) ? 2 : w_set;
      hh = (h_set < 2) ? 2 : h_set;
      frames = $urandom_range(1, 3);
      for (int f = 0; f < frames; f++) begin
        mode = $urandom_range(0, 9);
        if (mode <= 6) begin
          send_frame(ww * hh, ww + 1 + (($urandom_range(0, 3) == 0) ? 2 : 0));
        end else if (mode == 7) begin
          send_frame(ww * hh, $urandom_range(1, ww));  // next frame drops the rest
        end else if (mode == 8 || f != frames - 1) begin
          send_frame(ww * hh, 0);
        end else begin
          repeat ($urandom_range(1, 2 * ww * hh)) begin
            send_word(($urandom_range(0, 9) < 3) ? KindDrain : KindPixel, rand_pixel());
          end
        end
        if ($urandom_range(0, 3) == 0) wait_idle();
      end
    end
  endtask

  initial begin
    model_reset();
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_startup();
    test_tiny_frame();
    test_border_and_restart();
    test_back_to_back();
    test_size_extremes();
    test_random_frames();

    wait_idle();
    $display("Sent %0d words (%0d drains), checked %0d results, %0d register writes.",
             words_sent, drains_sent, results_checked, reg_writes);
    $display("Frames from 2x2 up to 1024-wide rows, restarts, stray drains, stalls.");
    if (mismatches == 0 && edge_results_q.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
design/scem_pkg.sv
design/scem_ram.sv
design/scem_ctrl.sv
design/scem_grad.sv
design/scharr_edge_magnitude_core.sv
tb/tb_scharr_edge_magnitude_core.sv
